[src/rounded_border_coverage_unit_macros.svh]
// assertion helpers for the coverage unit checker
`ifndef ROUNDED_BORDER_COVERAGE_UNIT_MACROS_SVH
`define ROUNDED_BORDER_COVERAGE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rbc_pkg.sv]
`default_nettype none
package rbc_pkg;
   localparam int COORD_BITS     = 12;
   localparam int FRAC_BITS      = 4;
   localparam int COVERAGE_BITS  = 8;
   localparam int REG_BITS       = 16;
   localparam int REG_COUNT      = 7;
   localparam int CSR_INDEX_BITS = $clog2(REG_COUNT);

   localparam int PIX_BITS  = COORD_BITS + FRAC_BITS;
   localparam int POS_BITS  = ((PIX_BITS > REG_BITS) ? PIX_BITS : REG_BITS) + 3;
   localparam int SQ_SHIFT  = 16;
   localparam int DIST_FRAC = FRAC_BITS + 8;
   localparam int SUM_BITS  = 2 * POS_BITS + 1;
   localparam int ROOT_BITS = (SUM_BITS + SQ_SHIFT + 1) / 2;
   localparam int V_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int TW_BITS   = ROOT_BITS + 2;
   localparam int T_BITS    = DIST_FRAC + 1;
   localparam int FAC_BITS  = DIST_FRAC + 2;
   localparam int TSQ_BITS  = 2 * T_BITS - 1;
   localparam int S_BITS    = TSQ_BITS + FAC_BITS;
   localparam int CUBE_SH   = 3 * DIST_FRAC - 16;
   localparam int Q_FRAC    = 16;
   localparam int Q_BITS    = Q_FRAC + 1;
   localparam int ALPHA_BITS = 2 * Q_FRAC + 1;
   localparam int COV_LAT   = ROOT_BITS + 7;

   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((COVERAGE_BITS + 7) / 8) * 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_WIDTH    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_HEIGHT   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_TL     = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_TR     = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_BR     = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_BL     = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BORDER_WIDTH  = CSR_INDEX_BITS'(6);

   typedef logic signed [POS_BITS-1:0] pos_type;
   typedef logic [REG_BITS-1:0]        reg_type;
   typedef logic [3:0][REG_BITS-1:0]   rad_set_type;
   typedef logic [Q_BITS-1:0]          q_type;

   localparam q_type Q_ONE = q_type'(1) << Q_FRAC;
endpackage
`default_nettype wire

[src/rbc_corner.sv]
`default_nettype none
module rbc_corner (
   input  logic                 clock,
   input  logic                 adv,
   input  rbc_pkg::pos_type     pos_x,
   input  rbc_pkg::pos_type     pos_y,
   input  rbc_pkg::pos_type     size_w,
   input  rbc_pkg::pos_type     size_h,
   input  rbc_pkg::rad_set_type rad,
   output rbc_pkg::q_type       cov
);
   import rbc_pkg::*;

   localparam logic [TW_BITS-1:0] T_ONE  = TW_BITS'(1) << DIST_FRAC;
   localparam logic [TW_BITS-1:0] T_HALF = TW_BITS'(1) << (DIST_FRAC - 1);
   localparam logic [FAC_BITS-1:0] THREE_ONE = FAC_BITS'(3) << DIST_FRAC;
   localparam logic [S_BITS-1:0] ONE_CUBE = S_BITS'(1) << (3 * DIST_FRAC);
   localparam logic [S_BITS-1:0] CUBE_RND = S_BITS'(1) << (CUBE_SH - 1);

   pos_type                 r_s [4];
   pos_type                 cx, cy;
   reg_type                 r_sel;
   logic                    hit_in;
   logic [POS_BITS:0]       dx, dy, nx, ny;
   logic [POS_BITS-1:0]     mx_in, my_in;

   logic [POS_BITS-1:0]     mx_ff, my_ff;
   reg_type                 r1_ff, r2_ff;
   logic                    hit1_ff, hit2_ff;
   logic [2*POS_BITS-1:0]   sqx_ff, sqy_ff;
   logic [SUM_BITS-1:0]     sum_in;

   logic [V_BITS-1:0]       v_ff    [ROOT_BITS];
   logic [REM_BITS-1:0]     rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]    root_ff [ROOT_BITS+1];
   reg_type                 rq_ff   [ROOT_BITS+1];
   logic                    hq_ff   [ROOT_BITS+1];

   logic [TW_BITS-1:0]      tw_in;
   logic [T_BITS-1:0]       t_in, t_ff;
   logic                    hit_t_ff, hit_p_ff, hit_s_ff;
   logic [TSQ_BITS-1:0]     tsq_ff;
   logic [FAC_BITS-1:0]     fac_ff;
   logic [S_BITS-1:0]       s_ff, c_in, rnd_in;
   q_type                   cov_ff;

   // corner pick, first hit in tl, tr, br, bl order
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r_s[k] = pos_type'(rad[k]);
      end
      hit_in = 1'b1;
      r_sel  = rad[0];
      cx     = r_s[0];
      cy     = r_s[0];
      if (pos_x < r_s[0] && pos_y < r_s[0]) begin
         cx = r_s[0]; cy = r_s[0]; r_sel = rad[0];
      end else if ((size_w - r_s[1]) < pos_x && pos_y < r_s[1]) begin
         cx = size_w - r_s[1]; cy = r_s[1]; r_sel = rad[1];
      end else if ((size_w - r_s[2]) < pos_x && (size_h - r_s[2]) < pos_y) begin
         cx = size_w - r_s[2]; cy = size_h - r_s[2]; r_sel = rad[2];
      end else if (pos_x < r_s[3] && (size_h - r_s[3]) < pos_y) begin
         cx = r_s[3]; cy = size_h - r_s[3]; r_sel = rad[3];
      end else begin
         hit_in = 1'b0;
      end
      dx = {pos_x[POS_BITS-1], pos_x} - {cx[POS_BITS-1], cx};
      dy = {pos_y[POS_BITS-1], pos_y} - {cy[POS_BITS-1], cy};
      nx = ~dx + 1'b1;
      ny = ~dy + 1'b1;
      mx_in = dx[POS_BITS] ? nx[POS_BITS-1:0] : dx[POS_BITS-1:0];
      my_in = dy[POS_BITS] ? ny[POS_BITS-1:0] : dy[POS_BITS-1:0];
   end

   assign sum_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff      <= mx_in;
         my_ff      <= my_in;
         r1_ff      <= r_sel;
         hit1_ff    <= hit_in;
         sqx_ff     <= mx_ff * mx_ff;
         sqy_ff     <= my_ff * my_ff;
         r2_ff      <= r1_ff;
         hit2_ff    <= hit1_ff;
         v_ff[0]    <= V_BITS'({sum_in, {SQ_SHIFT{1'b0}}});
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rq_ff[0]   <= r2_ff;
         hq_ff[0]   <= hit2_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      logic [REM_BITS-1:0] shifted, trial, diff;
      logic                take;
      assign shifted = {rem_ff[k][ROOT_BITS-1:0], v_ff[k][V_BITS-1 -: 2]};
      assign trial   = {root_ff[k], 2'b01};
      assign take    = shifted >= trial;
      assign diff    = shifted - trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k+1] <= {root_ff[k][ROOT_BITS-2:0], take};
            rq_ff[k+1]   <= rq_ff[k];
            hq_ff[k+1]   <= hq_ff[k];
         end
      end
      if (k < ROOT_BITS - 1) begin : g_next
         always_ff @(posedge clock) begin
            if (adv) begin
               v_ff[k+1]   <= {v_ff[k][V_BITS-3:0], 2'b00};
               rem_ff[k+1] <= take ? diff : shifted;
            end
         end
      end
   end

   // t = clamp(d - r + 1/2, 0, 1)
   always_comb begin
      tw_in = {2'b00, root_ff[ROOT_BITS]}
            - TW_BITS'({rq_ff[ROOT_BITS], 8'b0}) + T_HALF;
      if (tw_in[TW_BITS-1]) begin
         t_in = '0;
      end else if (tw_in > T_ONE) begin
         t_in = T_ONE[T_BITS-1:0];
      end else begin
         t_in = tw_in[T_BITS-1:0];
      end
      c_in   = ONE_CUBE - s_ff;
      rnd_in = c_in + CUBE_RND;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         hit_t_ff <= hq_ff[ROOT_BITS];
         tsq_ff   <= t_ff * t_ff;
         fac_ff   <= THREE_ONE - {t_ff, 1'b0};
         hit_p_ff <= hit_t_ff;
         s_ff     <= tsq_ff * fac_ff;
         hit_s_ff <= hit_p_ff;
         cov_ff   <= hit_s_ff ? rnd_in[CUBE_SH +: Q_BITS] : Q_ONE;
      end
   end

   assign cov = cov_ff;
endmodule
`default_nettype wire

[src/rounded_border_coverage_unit.sv]
// channel   direction  payload (low bit first)
// req       in         pixel_x, pixel_y
// rsp       out        coverage
// csr       in         register index, write data
//
// one pixel per clock while rsp is not stalled
// the square root has 28 stages, one root bit per stage
// reset is synchronous, clears valid bits and the csr registers
// a stall on rsp freezes the whole pipeline, nothing is lost or repeated
// csr writes are always accepted
`default_nettype none
module rounded_border_coverage_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rbc_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // pixel_x, pixel_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rbc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // coverage
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rbc_pkg::REG_BITS-1:0]        csr_data
);
   import rbc_pkg::*;

   reg_type rect_w_ff, rect_h_ff, rad_tl_ff, rad_tr_ff, rad_br_ff, rad_bl_ff, bw_ff;

   logic                    adv;
   logic                    vld0_ff, vld1_ff, vldm_ff, out_vld_ff;
   logic [COORD_BITS-1:0]   x0_ff, y0_ff;

   pos_type                 px_in, py_in, bw_s, bw2_s, w_s, h_s;
   pos_type                 ix_in, iy_in, iw_in, ih_in;
   rad_set_type             orad, irad_in;
   logic                    ap_in;

   pos_type                 px_ff, py_ff, ix_ff, iy_ff, iw_ff, ih_ff;
   rad_set_type             irad_ff;
   logic                    ap1_ff;

   q_type                   outer_cov, inner_cov;
   logic                    dvld_ff [COV_LAT];
   logic                    dap_ff  [COV_LAT];

   logic [2*Q_BITS-1:0]     prod_in;
   logic [ALPHA_BITS-1:0]   alpha_in, alpha_ff;
   logic [ALPHA_BITS+COVERAGE_BITS:0] scaled_in;
   logic [COVERAGE_BITS-1:0] out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_w_ff <= '0; rect_h_ff <= '0;
         rad_tl_ff <= '0; rad_tr_ff <= '0; rad_br_ff <= '0; rad_bl_ff <= '0;
         bw_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RECT_WIDTH:   rect_w_ff <= csr_data;
            CSR_RECT_HEIGHT:  rect_h_ff <= csr_data;
            CSR_RADIUS_TL:    rad_tl_ff <= csr_data;
            CSR_RADIUS_TR:    rad_tr_ff <= csr_data;
            CSR_RADIUS_BR:    rad_br_ff <= csr_data;
            CSR_RADIUS_BL:    rad_bl_ff <= csr_data;
            CSR_BORDER_WIDTH: bw_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // inner rectangle geometry
   always_comb begin
      orad    = {rad_bl_ff, rad_br_ff, rad_tr_ff, rad_tl_ff};
      px_in   = pos_type'({x0_ff, 1'b1, {(FRAC_BITS-1){1'b0}}});
      py_in   = pos_type'({y0_ff, 1'b1, {(FRAC_BITS-1){1'b0}}});
      w_s     = pos_type'(rect_w_ff);
      h_s     = pos_type'(rect_h_ff);
      bw_s    = pos_type'(bw_ff);
      bw2_s   = pos_type'({bw_ff, 1'b0});
      ix_in   = px_in - bw_s;
      iy_in   = py_in - bw_s;
      iw_in   = w_s - bw2_s;
      ih_in   = h_s - bw2_s;
      for (int k = 0; k < 4; k++) begin
         irad_in[k] = (orad[k] > bw_ff) ? orad[k] - bw_ff : '0;
      end
      ap_in = (bw_ff != '0) && !ix_in[POS_BITS-1] && !iy_in[POS_BITS-1]
              && (ix_in <= iw_in) && (iy_in <= ih_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff   <= req_tdata[COORD_BITS-1:0];
         y0_ff   <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         px_ff   <= px_in;
         py_ff   <= py_in;
         ix_ff   <= ix_in;
         iy_ff   <= iy_in;
         iw_ff   <= iw_in;
         ih_ff   <= ih_in;
         irad_ff <= irad_in;
         ap1_ff  <= ap_in;
         dap_ff[0] <= ap1_ff;
         for (int k = 1; k < COV_LAT; k++) begin
            dap_ff[k] <= dap_ff[k-1];
         end
         alpha_ff <= alpha_in;
         out_ff   <= scaled_in[2*Q_FRAC +: COVERAGE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff    <= 1'b0;
         vld1_ff    <= 1'b0;
         vldm_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < COV_LAT; k++) begin
            dvld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld0_ff    <= req_tvalid;
         vld1_ff    <= vld0_ff;
         dvld_ff[0] <= vld1_ff;
         for (int k = 1; k < COV_LAT; k++) begin
            dvld_ff[k] <= dvld_ff[k-1];
         end
         vldm_ff    <= dvld_ff[COV_LAT-1];
         out_vld_ff <= vldm_ff;
      end
   end

   rbc_corner u_outer (
      .clock  (clock),
      .adv    (adv),
      .pos_x  (px_ff),
      .pos_y  (py_ff),
      .size_w (w_s),
      .size_h (h_s),
      .rad    (orad),
      .cov    (outer_cov)
   );

   rbc_corner u_inner (
      .clock  (clock),
      .adv    (adv),
      .pos_x  (ix_ff),
      .pos_y  (iy_ff),
      .size_w (iw_ff),
      .size_h (ih_ff),
      .rad    (irad_ff),
      .cov    (inner_cov)
   );

   // outer times one minus inner when a border applies, else outer alone, then scale to output range
   always_comb begin
      prod_in  = outer_cov * (Q_ONE - inner_cov);
      alpha_in = dap_ff[COV_LAT-1] ? prod_in[ALPHA_BITS-1:0]
                                   : ALPHA_BITS'({outer_cov, {Q_FRAC{1'b0}}});
      scaled_in = {1'b0, alpha_ff, {COVERAGE_BITS{1'b0}}}
                - (ALPHA_BITS+COVERAGE_BITS+1)'(alpha_ff)
                + ((ALPHA_BITS+COVERAGE_BITS+1)'(1) << (2*Q_FRAC - 1));
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_ff);
endmodule
`default_nettype wire

[src/rbc_checker.sv]
`default_nettype none
`include "rounded_border_coverage_unit_macros.svh"
module rbc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rbc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                csr_ready
);
   `RBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")
   `RBC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data changed while stalled")
   `RBC_ASSERT_NOW(a_empty_flows, clock, reset, !rsp_tvalid, req_tready, "pipeline stalled with empty output")
   `RBC_ASSERT_NOW(a_drain_flows, clock, reset, rsp_tvalid && rsp_tready, req_tready && csr_ready, "input stalled during output transfer")
endmodule

bind rounded_border_coverage_unit rbc_checker u_rbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
`default_nettype wire
